@@ rtl/stepper_driver_uart_write_framer_macros.svh @@
// Assertion macros shared by the register-write framer.
`ifndef STEPPER_DRIVER_UART_WRITE_FRAMER_MACROS_SVH
`define STEPPER_DRIVER_UART_WRITE_FRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define SDUWF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("framer assertion failed");
`define SDUWF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("framer assertion failed");
`else
`define SDUWF_ASSERT_SAME(lbl, ante, cons)
`define SDUWF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/sduwf_pkg.sv @@
// Types, constants and helper functions of the register-write framer.
`timescale 1ns / 1ps
package sduwf_pkg;

    localparam logic [1:0] CMD_INIT      = 2'd0;
    localparam logic [1:0] CMD_MICROSTEP = 2'd1;
    localparam logic [1:0] CMD_CURRENT   = 2'd2;

    localparam logic [7:0]  SYNC_BYTE        = 8'h05;
    localparam logic [7:0]  WRITE_FLAG       = 8'h80;
    localparam logic [7:0]  CRC_POLY         = 8'h07;
    localparam logic [7:0]  REG_GCONF        = 8'h00;
    localparam logic [7:0]  REG_IHOLD_IRUN   = 8'h10;
    localparam logic [7:0]  REG_CHOPCONF     = 8'h6C;
    localparam logic [31:0] GCONF_INIT_BITS  = 32'h0000_00C0;
    localparam logic [31:0] CHOPCONF_DEFAULT = 32'h1001_0053;
    localparam logic [31:0] MRES_MASK        = 32'h0F00_0000;
    localparam logic [31:0] VSENSE_MASK      = 32'h0002_0000;
    localparam logic [19:0] K_NORMAL         = 20'd303699;
    localparam logic [19:0] K_HIGHSENSE      = 20'd548346;
    localparam logic [11:0] SCALE_LOW_LIMIT  = 12'd16;
    localparam logic [11:0] SCALE_MAX        = 12'd31;
    localparam logic [2:0]  LAST_BYTE        = 3'd7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       datagram_end;
        logic       run_end;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_NORM,
        ST_CHECK,
        ST_MUL_HIGH,
        ST_SCALE,
        ST_SEND,
        ST_LOAD_HOLD
    } state_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_GCONF,
        KIND_MRES,
        KIND_CURRENT
    } kind_t;

    typedef enum logic [1:0] {
        DG_GCONF,
        DG_MRES,
        DG_CHOP_VS,
        DG_IHOLD
    } dg_sel_t;

    typedef struct packed {
        logic    capture;
        logic    mul;
        logic    mul_high;
        logic    take_scale;
        logic    load;
        dg_sel_t dg_sel;
        logic    emit;
        logic    last_run;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  scale_low;
        logic  byte_last;
        logic  out_free;
    } dp_status_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            if (c[7] ^ data[i]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Returns {valid, code}; code 8 stands for full steps.
    function automatic logic [4:0] mres_code(input logic [15:0] count);
        logic [4:0] r;
        r = 5'd0;
        unique case (count)
            16'd256: r = {1'b1, 4'd0};
            16'd128: r = {1'b1, 4'd1};
            16'd64:  r = {1'b1, 4'd2};
            16'd32:  r = {1'b1, 4'd3};
            16'd16:  r = {1'b1, 4'd4};
            16'd8:   r = {1'b1, 4'd5};
            16'd4:   r = {1'b1, 4'd6};
            16'd2:   r = {1'b1, 4'd7};
            16'd0:   r = {1'b1, 4'd8};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/sduwf_ctrl.sv @@
// Controller state machine that sequences decode, scaling and datagram transfers.
`timescale 1ns / 1ps
module sduwf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sduwf_pkg::dp_status_t status,
    output sduwf_pkg::ctrl_cmd_t  cmd
);

    sduwf_pkg::state_t state_reg, state_next;
    logic              second_reg, second_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sduwf_pkg::ST_IDLE;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        second_next = second_reg;
        unique case (state_reg)
            sduwf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sduwf_pkg::ST_DECODE;
                end
            end
            sduwf_pkg::ST_DECODE: begin
                unique case (status.kind)
                    sduwf_pkg::KIND_GCONF, sduwf_pkg::KIND_MRES: begin
                        state_next  = sduwf_pkg::ST_SEND;
                        second_next = 1'b0;
                    end
                    sduwf_pkg::KIND_CURRENT: begin
                        state_next  = sduwf_pkg::ST_MUL_NORM;
                        second_next = 1'b1;
                    end
                    default: state_next = sduwf_pkg::ST_IDLE;
                endcase
            end
            sduwf_pkg::ST_MUL_NORM: state_next = sduwf_pkg::ST_CHECK;
            sduwf_pkg::ST_CHECK: begin
                state_next = status.scale_low ? sduwf_pkg::ST_MUL_HIGH : sduwf_pkg::ST_SEND;
            end
            sduwf_pkg::ST_MUL_HIGH: state_next = sduwf_pkg::ST_SCALE;
            sduwf_pkg::ST_SCALE:    state_next = sduwf_pkg::ST_SEND;
            sduwf_pkg::ST_SEND: begin
                if (status.out_free && status.byte_last) begin
                    state_next = second_reg ? sduwf_pkg::ST_LOAD_HOLD : sduwf_pkg::ST_IDLE;
                end
            end
            sduwf_pkg::ST_LOAD_HOLD: begin
                state_next  = sduwf_pkg::ST_SEND;
                second_next = 1'b0;
            end
            default: state_next = sduwf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.dg_sel     = sduwf_pkg::DG_GCONF;
        unique case (state_reg)
            sduwf_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            sduwf_pkg::ST_DECODE: begin
                cmd.load   = (status.kind == sduwf_pkg::KIND_GCONF) ||
                             (status.kind == sduwf_pkg::KIND_MRES);
                cmd.dg_sel = (status.kind == sduwf_pkg::KIND_MRES) ?
                             sduwf_pkg::DG_MRES : sduwf_pkg::DG_GCONF;
            end
            sduwf_pkg::ST_MUL_NORM: cmd.mul = 1'b1;
            sduwf_pkg::ST_CHECK: begin
                cmd.load       = 1'b1;
                cmd.dg_sel     = sduwf_pkg::DG_CHOP_VS;
                cmd.take_scale = !status.scale_low;
            end
            sduwf_pkg::ST_MUL_HIGH: begin
                cmd.mul      = 1'b1;
                cmd.mul_high = 1'b1;
            end
            sduwf_pkg::ST_SCALE: cmd.take_scale = 1'b1;
            sduwf_pkg::ST_SEND: begin
                cmd.emit     = status.out_free;
                cmd.last_run = !second_reg;
            end
            sduwf_pkg::ST_LOAD_HOLD: begin
                cmd.load   = 1'b1;
                cmd.dg_sel = sduwf_pkg::DG_IHOLD;
            end
            default: s_ready = 1'b0;
        endcase
    end

endmodule

@@ rtl/sduwf_datapath.sv @@
// Datapath: shadow registers, current scaling, datagram bytes, CRC and output register.
`timescale 1ns / 1ps
module sduwf_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sduwf_pkg::ctrl_cmd_t  cmd,
    output sduwf_pkg::dp_status_t status,
    input  sduwf_pkg::in_item_t   s_data,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sduwf_pkg::out_item_t  m_data
);

    logic [1:0]           node_reg;
    logic [1:0]           cmd_reg;
    logic [15:0]          value_reg;
    logic [31:0]          gconf_reg, gconf_next;
    logic [31:0]          chop_reg, chop_next;
    logic [35:0]          prod_reg;
    logic [4:0]           scale_reg;
    logic [7:0]           dg_addr_reg, dg_addr_next;
    logic [31:0]          dg_val_reg, dg_val_next;
    logic [2:0]           idx_reg;
    logic [7:0]           crc_reg;
    logic                 m_valid_reg;
    sduwf_pkg::out_item_t m_data_reg;

    logic [4:0]  mres;
    logic [11:0] p_top;
    logic [11:0] scale_raw;
    logic [4:0]  scale_sat;
    logic [7:0]  cur_byte;
    logic [19:0] k_sel;

    assign mres      = sduwf_pkg::mres_code(value_reg);
    assign p_top     = prod_reg[35:24];
    assign scale_raw = (p_top != 12'd0) ? (p_top - 12'd1) : 12'd0;
    assign scale_sat = (scale_raw > sduwf_pkg::SCALE_MAX) ? sduwf_pkg::SCALE_MAX[4:0]
                                                          : scale_raw[4:0];
    assign k_sel     = cmd.mul_high ? sduwf_pkg::K_HIGHSENSE : sduwf_pkg::K_NORMAL;

    always_comb begin
        unique case (cmd_reg)
            sduwf_pkg::CMD_INIT:      status.kind = sduwf_pkg::KIND_GCONF;
            sduwf_pkg::CMD_MICROSTEP: status.kind = mres[4] ? sduwf_pkg::KIND_MRES
                                                           : sduwf_pkg::KIND_NONE;
            sduwf_pkg::CMD_CURRENT:   status.kind = sduwf_pkg::KIND_CURRENT;
            default:                  status.kind = sduwf_pkg::KIND_NONE;
        endcase
        status.scale_low = scale_raw < sduwf_pkg::SCALE_LOW_LIMIT;
        status.byte_last = idx_reg == sduwf_pkg::LAST_BYTE;
        status.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        gconf_next   = gconf_reg;
        chop_next    = chop_reg;
        dg_addr_next = dg_addr_reg;
        dg_val_next  = dg_val_reg;
        if (cmd.load) begin
            unique case (cmd.dg_sel)
                sduwf_pkg::DG_GCONF: begin
                    gconf_next   = gconf_reg | sduwf_pkg::GCONF_INIT_BITS;
                    chop_next    = sduwf_pkg::CHOPCONF_DEFAULT;
                    dg_addr_next = sduwf_pkg::REG_GCONF;
                    dg_val_next  = gconf_reg | sduwf_pkg::GCONF_INIT_BITS;
                end
                sduwf_pkg::DG_MRES: begin
                    chop_next    = (chop_reg & ~sduwf_pkg::MRES_MASK) |
                                   {4'd0, mres[3:0], 24'd0};
                    dg_addr_next = sduwf_pkg::REG_CHOPCONF;
                    dg_val_next  = (chop_reg & ~sduwf_pkg::MRES_MASK) |
                                   {4'd0, mres[3:0], 24'd0};
                end
                sduwf_pkg::DG_CHOP_VS: begin
                    chop_next    = status.scale_low ? (chop_reg | sduwf_pkg::VSENSE_MASK)
                                                    : (chop_reg & ~sduwf_pkg::VSENSE_MASK);
                    dg_addr_next = sduwf_pkg::REG_CHOPCONF;
                    dg_val_next  = chop_next;
                end
                sduwf_pkg::DG_IHOLD: begin
                    dg_addr_next = sduwf_pkg::REG_IHOLD_IRUN;
                    dg_val_next  = {19'd0, scale_reg, 3'd0, 1'b0, scale_reg[4:1]};
                end
                default: dg_addr_next = dg_addr_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx_reg)
            3'd0:    cur_byte = sduwf_pkg::SYNC_BYTE;
            3'd1:    cur_byte = {6'd0, node_reg};
            3'd2:    cur_byte = dg_addr_reg | sduwf_pkg::WRITE_FLAG;
            3'd3:    cur_byte = dg_val_reg[31:24];
            3'd4:    cur_byte = dg_val_reg[23:16];
            3'd5:    cur_byte = dg_val_reg[15:8];
            3'd6:    cur_byte = dg_val_reg[7:0];
            default: cur_byte = crc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg    <= 2'd0;
            gconf_reg   <= 32'd0;
            chop_reg    <= 32'd0;
            m_valid_reg <= 1'b0;
            idx_reg     <= 3'd0;
            crc_reg     <= 8'd0;
        end else begin
            if (cfg_valid) begin
                node_reg <= cfg_data;
            end
            gconf_reg <= gconf_next;
            chop_reg  <= chop_next;
            if (cmd.load) begin
                idx_reg <= 3'd0;
                crc_reg <= 8'd0;
            end else if (cmd.emit) begin
                idx_reg <= idx_reg + 3'd1;
                crc_reg <= sduwf_pkg::crc_feed(crc_reg, cur_byte);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dg_addr_reg <= dg_addr_next;
        dg_val_reg  <= dg_val_next;
        if (cmd.capture) begin
            cmd_reg   <= s_data.cmd;
            value_reg <= s_data.value;
        end
        if (cmd.mul) begin
            prod_reg <= {20'd0, value_reg} * {16'd0, k_sel};
        end
        if (cmd.take_scale) begin
            scale_reg <= scale_sat;
        end
        if (cmd.emit) begin
            m_data_reg.tx_byte      <= cur_byte;
            m_data_reg.datagram_end <= status.byte_last;
            m_data_reg.run_end      <= status.byte_last && cmd.last_run;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/stepper_driver_uart_write_framer.sv @@
// Top level of the UART register-write datagram framer for a stepper driver.
//
//  channel  ports                      payload
//  input    s_valid s_ready s_data     cmd, value
//  result   m_valid m_ready m_data     tx_byte, datagram_end, run_end
//  config   cfg_valid cfg_ready        cfg_data = node address
//
// One command is taken at a time. Init and microstep commands go from the transfer to a
// decode state, then send eight bytes, one byte per cycle while the result side does not
// stall. A current command adds the normal multiply and check states, the high-sensitivity
// multiply and scale states when that scale is needed, and a load state for the second
// datagram; it sends sixteen bytes. An ignored command is decoded and sends nothing.
// A stall on the result side holds the byte sequencer. Reset clears the shadow registers,
// the node address and all control state; no clearing pass is needed.
`timescale 1ns / 1ps
`include "stepper_driver_uart_write_framer_macros.svh"
module stepper_driver_uart_write_framer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sduwf_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sduwf_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data
);

    sduwf_pkg::ctrl_cmd_t  cmd;
    sduwf_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    sduwf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sduwf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // The last byte of a command is always the CRC byte of a datagram.
    `SDUWF_ASSERT_SAME(a_run_end_on_crc, m_valid && m_data.run_end, m_data.datagram_end)
    // A command transfer makes the block busy in the next cycle.
    `SDUWF_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // A new command is taken only once every byte but the final one has gone out.
    `SDUWF_ASSERT_SAME(a_accept_after_run, s_valid && s_ready, !m_valid || m_data.run_end)

endmodule
